// ===== hw/rtl/ltpc_pkg.sv =====
// Shared types, codes and default parameters of the link test packet checker.
`timescale 1ns / 1ps

package ltpc_pkg;

    // Default parameter values.
    localparam int PACKET_BYTES_DEF  = 64;
    localparam int MERSENNE_EXP_DEF  = 31;

    // Register reset values.
    localparam logic [30:0] RESET_MULTIPLIER = 31'd16807;
    localparam logic [30:0] RESET_FIRST_SEQ  = 31'd1;

    // Stream widths.
    localparam int S_TDATA_W   = 24;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 168;
    localparam int M_TUSER_W   = 3;
    localparam int SESSION_BIT = 160;

    // Configuration port.
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 31;
    localparam logic [CFG_ADDR_W-1:0] REG_MULTIPLIER = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_FIRST_SEQ  = 1'b1;

    localparam logic [7:0] NO_NODE = 8'hFF;
    localparam logic [6:0] POS_MAX = 7'd127;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_END   = 2'd1,
        CMD_DATA  = 2'd2
    } t_command;

    typedef enum logic [2:0] {
        VERDICT_NONE    = 3'd0,
        VERDICT_NEW     = 3'd1,
        VERDICT_DUP     = 3'd2,
        VERDICT_ERROR   = 3'd3,
        VERDICT_IGNORED = 3'd4
    } t_verdict;

endpackage

// ===== hw/rtl/ltpc_lehmer.sv =====
// One step of the Lehmer pattern generator modulo a Mersenne prime.
`timescale 1ns / 1ps

module ltpc_lehmer #(
    parameter int MERSENNE_EXPONENT = 31
) (
    input  logic [MERSENNE_EXPONENT-1:0] i_state,
    input  logic [MERSENNE_EXPONENT-1:0] i_mult,
    output logic [MERSENNE_EXPONENT-1:0] o_next
);

    localparam int E = MERSENNE_EXPONENT;
    localparam logic [E-1:0] MODULUS = {E{1'b1}};

    logic [2*E-1:0] product;
    logic [E:0]     sum_hi_lo;
    logic [E-1:0]   folded;

    // Both operands are already below the modulus, so two folds bring the
    // product into range; only the modulus itself is left to map to zero.
    assign product   = i_state * i_mult;
    assign sum_hi_lo = {1'b0, product[2*E-1:E]} + {1'b0, product[E-1:0]};
    assign folded    = sum_hi_lo[E-1:0] + E'(sum_hi_lo[E]);
    assign o_next    = (folded == MODULUS) ? '0 : folded;

endmodule

// ===== hw/rtl/link_test_packet_checker.sv =====
// Top level of the link test packet checker.
// The slave stream carries one packet byte or one session command per
// transaction. A start command binds the sending node and clears the
// statistics; an end command from the bound node releases it. Data bytes from
// the bound node are assembled into packets: a little-endian sequence number,
// then Lehmer pattern bytes. The last byte of a packet is judged.
// Every accepted input transaction produces exactly one master transaction
// with the updated sequence, counters, session flag and a verdict.
// After a slave transaction is accepted, its result reaches the master side
// through one input register, then a single pass (one multiply and fold of
// the generator) into the result register. One transaction is taken per
// cycle while the master side is ready; the generator multiply-fold sets the
// clock limit.
// When the master side stalls, the held result and one waiting input stay in
// place and slave tready drops until the result is taken. Synchronous reset
// empties both registers, unbinds the node, clears the statistics and
// restores the register defaults. Configuration is written through a plain
// write port; the user must write it only while the block idles, and the
// block itself does not enforce this.
`timescale 1ns / 1ps

module link_test_packet_checker
    import ltpc_pkg::*;
#(
    parameter int PACKET_BYTES      = PACKET_BYTES_DEF,
    parameter int MERSENNE_EXPONENT = MERSENNE_EXP_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // node_id [6:0], xfer_id [11:7], data_byte [19:12], zero [23:20]
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // command [1:0]
    input  logic [S_TUSER_W-1:0]  s_axis_tuser,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // received_sequence [31:0], duplicate_count [63:32], missing_count [95:64],
    // error_count [127:96], mismatch_count [159:128], session_active [160],
    // zero [167:161]
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // packet_verdict [2:0]
    output logic [M_TUSER_W-1:0]  m_axis_tuser
);

    localparam int E = MERSENNE_EXPONENT;
    localparam logic [E-1:0] MODULUS  = {E{1'b1}};
    localparam logic [6:0]   LAST_POS = 7'(PACKET_BYTES - 1);
    localparam logic [6:0]   DATA_END = 7'(PACKET_BYTES);

    // Exact reduction of a 32-bit value modulo the Mersenne prime.
    function automatic logic [E-1:0] mod_p32(input logic [31:0] value);
        logic [32:0] v;
        v = {1'b0, value};
        for (int k = 0; k < 3; k++) begin
            v = (v >> E) + (v & {{(33-E){1'b0}}, MODULUS});
        end
        return (v[E-1:0] == MODULUS) ? '0 : v[E-1:0];
    endfunction

    // Input register.
    logic       r_in_valid;
    t_command   r_in_cmd;
    logic [6:0] r_in_node;
    logic [4:0] r_in_tid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Result register.
    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;
    t_verdict             r_out_verdict;

    // Configuration.
    logic [E-1:0]  r_mult;
    logic [30:0]   r_first_seq;

    // Session and packet state.
    logic [7:0]   r_bound, n_bound;
    logic [31:0]  r_last_seq, n_last_seq;
    logic [31:0]  r_dup, n_dup;
    logic [31:0]  r_miss, n_miss;
    logic [31:0]  r_err, n_err;
    logic [31:0]  r_mism, n_mism;
    logic [4:0]   r_last_tid, n_last_tid;
    logic [6:0]   r_pos, n_pos;
    logic [31:0]  r_pkt_seq, n_pkt_seq;
    logic [E-1:0] r_pat, n_pat;
    logic         r_pat_bad, n_pat_bad;

    t_verdict     verdict;
    logic [31:0]  seq_asm;
    logic [31:0]  judge_seq;
    logic [31:0]  gap;
    logic [E-1:0] pat_next;
    logic         advance;
    logic         take;
    logic         node_match;

    assign advance       = !r_out_valid || m_axis_tready;
    assign take          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_verdict;

    ltpc_lehmer #(
        .MERSENNE_EXPONENT(MERSENNE_EXPONENT)
    ) u_lehmer (
        .i_state(r_pat),
        .i_mult (r_mult),
        .o_next (pat_next)
    );

    assign node_match = ({1'b0, r_in_node} == r_bound);
    assign seq_asm    = r_pkt_seq | (32'(r_in_byte) << {r_pos[1:0], 3'b000});
    assign judge_seq  = (r_pos < 7'd4) ? seq_asm : r_pkt_seq;
    assign gap        = judge_seq - r_last_seq;

    always_comb begin
        n_bound    = r_bound;
        n_last_seq = r_last_seq;
        n_dup      = r_dup;
        n_miss     = r_miss;
        n_err      = r_err;
        n_mism     = r_mism;
        n_last_tid = r_last_tid;
        n_pos      = r_pos;
        n_pkt_seq  = r_pkt_seq;
        n_pat      = r_pat;
        n_pat_bad  = r_pat_bad;
        verdict    = VERDICT_NONE;

        unique case (r_in_cmd)
            CMD_START: begin
                n_bound    = {1'b0, r_in_node};
                n_last_seq = {1'b0, r_first_seq} - 32'd1;
                n_dup      = '0;
                n_miss     = '0;
                n_err      = '0;
                n_mism     = '0;
                n_last_tid = r_in_tid;
                n_pos      = '0;
                n_pkt_seq  = '0;
                n_pat      = '0;
                n_pat_bad  = 1'b0;
            end
            CMD_END: begin
                if (node_match) begin
                    n_bound   = NO_NODE;
                    n_pos     = '0;
                    n_pkt_seq = '0;
                    n_pat     = '0;
                    n_pat_bad = 1'b0;
                end
            end
            CMD_DATA: begin
                if (!node_match) begin
                    verdict = VERDICT_IGNORED;
                end else begin
                    if (r_pos < 7'd4) begin
                        n_pkt_seq = seq_asm;
                        if (r_pos == 7'd3) begin
                            n_pat = mod_p32(seq_asm);
                        end
                    end else if (r_pos < DATA_END) begin
                        n_pat = pat_next;
                        if (pat_next[7:0] != r_in_byte) begin
                            n_pat_bad = 1'b1;
                        end
                    end
                    if (r_pos != POS_MAX) begin
                        n_pos = r_pos + 7'd1;
                    end
                    if (r_in_last) begin
                        if (r_pos != LAST_POS || n_pat_bad || gap[31]) begin
                            n_err   = r_err + 32'd1;
                            verdict = VERDICT_ERROR;
                        end else begin
                            if (gap == '0) begin
                                n_dup   = r_dup + 32'd1;
                                verdict = VERDICT_DUP;
                            end else begin
                                n_miss  = r_miss + gap - 32'd1;
                                verdict = VERDICT_NEW;
                            end
                            n_last_seq = judge_seq;
                            // The transfer id must advance by the gap, except on
                            // the first packet of a session or after a long gap.
                            if (gap < 32'd31 && judge_seq != {1'b0, r_first_seq} &&
                                (r_last_tid + gap[4:0]) != r_in_tid) begin
                                n_mism = r_mism + 32'd1;
                            end
                            n_last_tid = r_in_tid;
                        end
                        n_pos     = '0;
                        n_pkt_seq = '0;
                        n_pat     = '0;
                        n_pat_bad = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_mult        <= mod_p32({1'b0, RESET_MULTIPLIER});
            r_first_seq   <= RESET_FIRST_SEQ;
            r_bound       <= NO_NODE;
            r_last_seq    <= '0;
            r_dup         <= '0;
            r_miss        <= '0;
            r_err         <= '0;
            r_mism        <= '0;
            r_last_tid    <= '0;
            r_pos         <= '0;
            r_pkt_seq     <= '0;
            r_pat         <= '0;
            r_pat_bad     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_MULTIPLIER: r_mult      <= mod_p32({1'b0, i_cfg_wdata});
                    REG_FIRST_SEQ:  r_first_seq <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end

            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
                r_in_cmd   <= t_command'(s_axis_tuser);
                r_in_node  <= s_axis_tdata[6:0];
                r_in_tid   <= s_axis_tdata[11:7];
                r_in_byte  <= s_axis_tdata[19:12];
                r_in_last  <= s_axis_tlast;
            end else if (take) begin
                r_in_valid <= 1'b0;
            end

            if (take) begin
                r_out_valid   <= 1'b1;
                r_out_verdict <= verdict;
                r_out_data    <= {7'b0, (n_bound != NO_NODE), n_mism, n_err, n_miss,
                                  n_dup, n_last_seq};
                r_bound       <= n_bound;
                r_last_seq    <= n_last_seq;
                r_dup         <= n_dup;
                r_miss        <= n_miss;
                r_err         <= n_err;
                r_mism        <= n_mism;
                r_last_tid    <= n_last_tid;
                r_pos         <= n_pos;
                r_pkt_seq     <= n_pkt_seq;
                r_pat         <= n_pat;
                r_pat_bad     <= n_pat_bad;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== hw/rtl/ltpc_checker.sv =====
// Port-level assertions of the link test packet checker and their binding.
`timescale 1ns / 1ps

module ltpc_checker
    import ltpc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [M_TDATA_W-1:0]  m_axis_tdata,
    input logic [M_TUSER_W-1:0]  m_axis_tuser
);

    // A stalled result transaction holds its contents.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // An accepted transaction reaches the master side, through the input and
    // result registers, when the receiver keeps taking results.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && m_axis_tready) ##1 m_axis_tready |=>
            m_axis_tvalid)
        else $error("result missing two cycles after acceptance");

    // Packet verdicts only come while a sender is bound.
    a_verdict_session: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[SESSION_BIT] |->
            m_axis_tuser != VERDICT_NEW && m_axis_tuser != VERDICT_DUP &&
            m_axis_tuser != VERDICT_ERROR)
        else $error("packet verdict without a bound sender");

endmodule

bind link_test_packet_checker ltpc_checker u_ltpc_checker (.*);
